FILE: hw/rtl/jfs_pkg.sv
// jfs_pkg: shared constants and types of the jacobi five point sweep block
`timescale 1ns / 1ps

package jfs_pkg;

  // configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 24;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_SIDE = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACCURACY  = 1'd1;

  // register field widths, side reset value and minimum side
  localparam int SIDE_BITS     = 11;
  localparam int ACCURACY_BITS = 24;
  localparam int RESET_SIDE    = 1024;
  localparam int MIN_SIDE      = 3;

  // per-cell control carried down the pipeline
  typedef struct packed {
    logic has_first;   // an upper-row cell is emitted
    logic interior;    // that cell takes the stencil average
    logic has_second;  // the arriving last-row cell is emitted too
    logic grid_end;    // the arriving cell is the final one of the grid
  } cell_flags_t;

endpackage

FILE: hw/rtl/jfs_cell_if.sv
// jfs_cell_if: input channel carrying one grid cell per word
`timescale 1ns / 1ps

interface jfs_cell_if #(
  parameter int VALUE_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

FILE: hw/rtl/jfs_result_if.sv
// jfs_result_if: output channel carrying one swept cell per word
`timescale 1ns / 1ps

interface jfs_result_if #(
  parameter int VALUE_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] new_value;
  logic [VALUE_BITS-1:0] max_change;
  logic                  settled;
  logic                  grid_end;

  modport source (output valid, output new_value, output max_change, output settled,
                  output grid_end, input ready);
  modport sink (input valid, input new_value, input max_change, input settled,
                input grid_end, output ready);
endinterface

FILE: hw/rtl/jacobi_five_point_sweep.sv
// jacobi_five_point_sweep: streaming five-point jacobi sweep with convergence tracking
`timescale 1ns / 1ps

// Takes one grid cell per cycle in raster order and returns the previous row swept, one
// cell per cycle, when neither channel stalls, via stages a, b, c and the output register.
// Cells of the last row each give two result words (the swept upper cell and the arriving
// cell itself), so that row is paced by the single output channel. Both line stores share
// one memory word per column; one read and one write of that memory per accepted cell set
// the one-cell-per-cycle rate. The read fetches the next cell's column, so the right
// neighbor of the cell above is registered on acceptance. The line stores are not cleared:
// the first rows of a sweep only fill them. grid_side is clamped to the range 3 to MAX_SIDE.
// The user writes registers only with no word in flight; the block does not enforce it.
module jacobi_five_point_sweep #(
  parameter int MAX_SIDE   = 1024,
  parameter int VALUE_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [jfs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [jfs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  jfs_cell_if.sink                           cell_in,
  jfs_result_if.source                       result_out
);

  localparam int COL_BITS   = $clog2(MAX_SIDE);
  localparam int CMP_W      = (jfs_pkg::SIDE_BITS > COL_BITS + 1) ? jfs_pkg::SIDE_BITS
                                                                   : COL_BITS + 1;
  localparam int ACC_W      = (jfs_pkg::ACCURACY_BITS < VALUE_BITS) ? jfs_pkg::ACCURACY_BITS
                                                                     : VALUE_BITS;
  localparam int SIDE_RESET = (jfs_pkg::RESET_SIDE > MAX_SIDE) ? MAX_SIDE
                                                               : jfs_pkg::RESET_SIDE;
  localparam logic [COL_BITS-1:0] LAST_RESET = COL_BITS'(SIDE_RESET - 1);
  localparam int SUM_W = VALUE_BITS + 2;

  // configuration
  logic [COL_BITS-1:0]   last_index;
  logic [VALUE_BITS-1:0] accuracy;
  logic [CMP_W-1:0]      side_req;
  logic [CMP_W-1:0]      side_eff;

  always_comb begin
    side_req = CMP_W'(cfg_data[jfs_pkg::SIDE_BITS-1:0]);
    if (side_req < CMP_W'(jfs_pkg::MIN_SIDE)) begin
      side_eff = CMP_W'(jfs_pkg::MIN_SIDE);
    end else if (side_req > CMP_W'(MAX_SIDE)) begin
      side_eff = CMP_W'(MAX_SIDE);
    end else begin
      side_eff = side_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_index <= LAST_RESET;
      accuracy   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        jfs_pkg::REG_GRID_SIDE: last_index <= COL_BITS'(side_eff - CMP_W'(1));
        jfs_pkg::REG_ACCURACY:  accuracy   <= VALUE_BITS'(cfg_data[ACC_W-1:0]);
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic a_valid, b_valid, c_valid, o_valid;
  logic a_free, b_free, c_free, o_load_ok;
  logic accept;
  logic c_emit, c_done;

  assign o_load_ok = !o_valid || result_out.ready;
  assign c_free    = !c_valid || c_done;
  assign b_free    = !b_valid || c_free;
  assign a_free    = !a_valid || b_free;
  assign accept    = cell_in.valid && a_free;
  assign cell_in.ready = a_free;

  // raster position
  logic [COL_BITS-1:0] column_count;
  logic [COL_BITS-1:0] row_count;
  logic [COL_BITS-1:0] column_count_next;
  logic                last_col, last_row;
  jfs_pkg::cell_flags_t in_flags;

  always_comb begin
    last_col = column_count >= last_index;
    last_row = row_count >= last_index;
    column_count_next = last_col ? '0 : column_count + COL_BITS'(1);
    in_flags.has_first  = row_count != '0;
    in_flags.interior   = (row_count != '0) && (row_count != COL_BITS'(1)) &&
                          (column_count != '0) && !last_col;
    in_flags.has_second = last_row;
    in_flags.grid_end   = last_row && last_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      if (last_col) begin
        row_count <= last_row ? '0 : row_count + COL_BITS'(1);
      end
    end
  end

  // line stores: {older row, previous row} per column
  logic [2*VALUE_BITS-1:0] line_mem [MAX_SIDE];
  logic [2*VALUE_BITS-1:0] rd_word;
  logic [VALUE_BITS-1:0]   rd_prev, rd_older;
  logic [VALUE_BITS-1:0]   left_hold;

  assign rd_prev  = rd_word[VALUE_BITS-1:0];
  assign rd_older = rd_word[2*VALUE_BITS-1:VALUE_BITS];

  // fetches the next cell's column, which holds the right neighbor of the cell above this one
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[column_count] <= {rd_prev, cell_in.cell_value};
      rd_word                <= line_mem[column_count_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_hold <= '0;
    end else if (accept) begin
      left_hold <= rd_prev;
    end
  end

  // stage a: gather neighbors, stencil sum
  logic [VALUE_BITS-1:0] a_value, a_above, a_top, a_left;
  jfs_pkg::cell_flags_t  a_flags;
  logic [SUM_W-1:0]      a_sum;
  logic [VALUE_BITS-1:0] a_new;

  always_comb begin
    // rd_word now holds the right neighbor
    a_sum = SUM_W'(a_top) + SUM_W'(a_value) + SUM_W'(a_left) + SUM_W'(rd_prev);
    a_new = a_flags.interior ? a_sum[SUM_W-1:2] : a_above;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_value <= cell_in.cell_value;
      a_above <= rd_prev;
      a_top   <= rd_older;
      a_left  <= left_hold;
      a_flags <= in_flags;
    end
  end

  // stage b: absolute change
  logic [VALUE_BITS-1:0] b_new, b_above, b_value;
  jfs_pkg::cell_flags_t  b_flags;
  logic [VALUE_BITS-1:0] b_diff;

  always_comb begin
    if (!b_flags.interior) begin
      b_diff = '0;
    end else if (b_new >= b_above) begin
      b_diff = b_new - b_above;
    end else begin
      b_diff = b_above - b_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_free) begin
      b_new   <= a_new;
      b_above <= a_above;
      b_value <= a_value;
      b_flags <= a_flags;
    end
  end

  // stage c: running maximum, none, one or two result words per cell
  logic [VALUE_BITS-1:0] c_new, c_diff, c_value;
  logic                  c_diff_ok;
  jfs_pkg::cell_flags_t  c_flags;
  logic                  c_phase;
  logic [VALUE_BITS-1:0] running_max;
  logic                  rm_ok, grow;
  logic [VALUE_BITS-1:0] max_first;
  logic                  ok_first;
  logic                  cur_is_first, cur_exists, c_last;

  always_comb begin
    rm_ok        = running_max <= accuracy;
    grow         = c_diff > running_max;
    max_first    = grow ? c_diff : running_max;
    ok_first     = grow ? c_diff_ok : rm_ok;
    cur_is_first = c_flags.has_first && !c_phase;
    cur_exists   = cur_is_first || c_flags.has_second;
    c_last       = !(cur_is_first && c_flags.has_second);
    c_emit       = c_valid && cur_exists && o_load_ok;
    c_done       = c_valid && c_last && (!cur_exists || o_load_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      c_phase <= 1'b0;
    end else begin
      if (c_free) begin
        c_valid <= b_valid;
        c_phase <= 1'b0;
      end else if (c_emit && cur_is_first) begin
        c_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && c_free) begin
      c_new     <= b_new;
      c_diff    <= b_diff;
      c_diff_ok <= b_diff <= accuracy;
      c_value   <= b_value;
      c_flags   <= b_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
    end else if (c_emit) begin
      if (cur_is_first) begin
        running_max <= max_first;
      end else if (c_flags.grid_end) begin
        running_max <= '0;
      end
    end
  end

  // output register
  logic [VALUE_BITS-1:0] o_new, o_max;
  logic                  o_settled, o_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_load_ok) begin
      o_valid <= c_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (c_emit) begin
      if (cur_is_first) begin
        o_new     <= c_new;
        o_max     <= max_first;
        o_settled <= ok_first;
        o_end     <= 1'b0;
      end else begin
        o_new     <= c_value;
        o_max     <= running_max;
        o_settled <= rm_ok;
        o_end     <= c_flags.grid_end;
      end
    end
  end

  assign result_out.valid      = o_valid;
  assign result_out.new_value  = o_new;
  assign result_out.max_change = o_max;
  assign result_out.settled    = o_settled;
  assign result_out.grid_end   = o_end;

`ifndef ASSERT_OFF
  // no forwarding path: the write and the read of one cell never meet in one entry
  assert property (@(posedge clk) disable iff (rst)
    accept |-> column_count != column_count_next)
    else $error("line store read and write hit the same column");

  // the sweep maximum starts over after the final cell leaves stage c
  assert property (@(posedge clk) disable iff (rst)
    (c_emit && !cur_is_first && c_flags.grid_end) |=> running_max == '0)
    else $error("running maximum not cleared at end of grid");

  // settled flag agrees with the reported change and the threshold
  assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> (result_out.settled == (result_out.max_change <= accuracy)))
    else $error("settled flag disagrees with max_change");
`endif

endmodule
